/* rtl/rpcc_pkg.sv */
`default_nettype none

package rpcc_pkg;

	localparam int POS_W         = 31;
	localparam int SCORE_W       = 16;
	localparam int MEAN_W        = 20;
	localparam int SPREAD_W      = 18;
	localparam int THRESH_W      = 16;
	localparam int DEV_W         = 16;
	localparam int DEV_FRAC      = 8;
	localparam int WINDOW_SIGMAS = 3;
	localparam int WINDOW_W      = 20;
	localparam int CFG_INDEX_W   = 4;
	localparam int CFG_DATA_W    = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_INSERT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INSERT_SPREAD   = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FUSION_ENABLE   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FUSION_THRESH   = 4'd3;

	typedef enum logic [1:0] {
		ORIENT_FR = 2'd0,
		ORIENT_RF = 2'd1,
		ORIENT_FF = 2'd2,
		ORIENT_RR = 2'd3
	} orient_t;

	typedef struct packed {
		logic [POS_W-1:0]          mate1_start;
		logic [POS_W-1:0]          mate1_end;
		logic [POS_W-1:0]          mate2_start;
		logic [POS_W-1:0]          mate2_end;
		logic signed [SCORE_W-1:0] mate1_score;
		logic signed [SCORE_W-1:0] mate2_score;
	} pair_t;

	typedef struct packed {
		orient_t          pair_orientation;
		logic [POS_W-1:0] observed_span;
		logic             concordant;
		logic             fusion_flag;
		logic [DEV_W-1:0] span_deviation;
	} result_t;

	// one restoring division step: {quotient bit, next remainder}
	function automatic logic [SPREAD_W:0] div_step(
		input logic [SPREAD_W-1:0] rem,
		input logic                nbit,
		input logic [SPREAD_W-1:0] dvs
	);
		logic [SPREAD_W:0] t;
		logic [SPREAD_W:0] d;
		logic [SPREAD_W:0] r;
		t = {rem, nbit};
		d = {1'b0, dvs};
		if (t >= d) begin
			r = t - d;
			return {1'b1, r[SPREAD_W-1:0]};
		end else begin
			return {1'b0, t[SPREAD_W-1:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/read_pair_concordance_classifier.sv */
// channel   | signals                                 | beat
// pair      | pair_valid, pair_ready, pair            | one read pair
// result    | result_valid, result_ready, result      | one classification
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// one pair enters per cycle while pair_ready is high; its result leaves from the last stage
// pipeline depth is set by the 16-bit deviation quotient, two bits per stage over 8 stages
// reset clears stage valid bits and all config registers
// each stage holds while its successor is full and stalled; empty stages fill in
// cfg writes are always accepted
`default_nettype none

module read_pair_concordance_classifier #(
	parameter int POSITION_BITS = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pair_valid,
	output logic                   pair_ready,
	input  wire rpcc_pkg::pair_t   pair,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output rpcc_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [rpcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rpcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rpcc_pkg::*;

	localparam int PB         = POSITION_BITS;
	localparam int DW         = (PB > MEAN_W) ? PB : MEAN_W;
	localparam int CW         = (DW > SPREAD_W + DEV_FRAC) ? DW : SPREAD_W + DEV_FRAC;
	localparam int DIV_STAGES = DEV_W / 2;
	localparam int NS         = 5 + DIV_STAGES;

	// config registers
	logic [MEAN_W-1:0]          mean_q;
	logic [SPREAD_W-1:0]        spread_q;
	logic                       fus_en_q;
	logic signed [THRESH_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= '0;
			spread_q <= '0;
			fus_en_q <= 1'b0;
			thr_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPECTED_INSERT: mean_q   <= cfg_data[MEAN_W-1:0];
				REG_INSERT_SPREAD:   spread_q <= cfg_data[SPREAD_W-1:0];
				REG_FUSION_ENABLE:   fus_en_q <= cfg_data[0];
				REG_FUSION_THRESH:   thr_q    <= $signed(cfg_data[THRESH_W-1:0]);
				default: ;
			endcase
		end
	end

	// stage valids and advance chain
	logic [NS:1]   vld;
	logic [NS+1:1] adv;

	assign adv[NS+1]    = result_ready;
	assign adv[NS:1]    = ~vld | adv[NS+1:2];
	assign pair_ready   = adv[1];
	assign result_valid = vld[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) begin
				vld[1] <= pair_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// stage 1: orientation, pairwise min/max, score tests
	logic [PB-1:0] s1c, e1c, s2c, e2c;
	logic [PB-1:0] lo01_s1, hi01_s1, lo23_s1, hi23_s1;
	orient_t       orient_s1;
	logic          sc_ok_s1;
	logic          fwd1, fwd2;
	orient_t       orient_c;

	assign s1c  = pair.mate1_start[PB-1:0];
	assign e1c  = pair.mate1_end[PB-1:0];
	assign s2c  = pair.mate2_start[PB-1:0];
	assign e2c  = pair.mate2_end[PB-1:0];
	assign fwd1 = s1c < e1c;
	assign fwd2 = s2c < e2c;

	always_comb begin
		case ({fwd1, fwd2})
			2'b10:   orient_c = ORIENT_FR;
			2'b01:   orient_c = ORIENT_RF;
			2'b11:   orient_c = ORIENT_FF;
			default: orient_c = ORIENT_RR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			lo01_s1   <= fwd1 ? s1c : e1c;
			hi01_s1   <= fwd1 ? e1c : s1c;
			lo23_s1   <= fwd2 ? s2c : e2c;
			hi23_s1   <= fwd2 ? e2c : s2c;
			orient_s1 <= orient_c;
			sc_ok_s1  <= (pair.mate1_score > thr_q) && (pair.mate2_score > thr_q);
		end
	end

	// stage 2: overall min and max
	logic [PB-1:0] lo_s2, hi_s2;
	orient_t       orient_s2;
	logic          sc_ok_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			lo_s2     <= (lo23_s1 < lo01_s1) ? lo23_s1 : lo01_s1;
			hi_s2     <= (hi23_s1 > hi01_s1) ? hi23_s1 : hi01_s1;
			orient_s2 <= orient_s1;
			sc_ok_s2  <= sc_ok_s1;
		end
	end

	// stage 3: span
	logic [PB-1:0] span_s3;
	orient_t       orient_s3;
	logic          sc_ok_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			span_s3   <= hi_s2 - lo_s2;
			orient_s3 <= orient_s2;
			sc_ok_s3  <= sc_ok_s2;
		end
	end

	// stage 4: distance from mean
	logic [DW-1:0] diff_s4;
	logic [PB-1:0] span_s4;
	orient_t       orient_s4;
	logic          sc_ok_s4;
	logic [DW-1:0] span_x, mean_x;

	assign span_x = DW'(span_s3);
	assign mean_x = DW'(mean_q);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			diff_s4   <= (span_x >= mean_x) ? span_x - mean_x : mean_x - span_x;
			span_s4   <= span_s3;
			orient_s4 <= orient_s3;
			sc_ok_s4  <= sc_ok_s3;
		end
	end

	// stage 5: window, fusion, saturation, divider setup
	logic [CW-1:0]       diff_x, wide_x, sat_lim;
	logic [WINDOW_W-1:0] wide;
	logic                conc_c;

	assign wide    = WINDOW_W'(spread_q) * WINDOW_W'(WINDOW_SIGMAS);
	assign diff_x  = CW'(diff_s4);
	assign wide_x  = CW'(wide);
	assign sat_lim = CW'({spread_q, {DEV_FRAC{1'b0}}});
	assign conc_c  = (orient_s4 inside {ORIENT_FR, ORIENT_RF}) && (diff_x <= wide_x);

	result_t             res_sd [0:DIV_STAGES];
	logic                sat_sd [0:DIV_STAGES];
	logic [SPREAD_W-1:0] rem_sd [0:DIV_STAGES];
	logic [DEV_W-1:0]    num_sd [0:DIV_STAGES];
	logic [DEV_W-1:0]    quo_sd [0:DIV_STAGES];

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			res_sd[0].pair_orientation <= orient_s4;
			res_sd[0].observed_span    <= POS_W'(span_s4);
			res_sd[0].concordant       <= conc_c;
			res_sd[0].fusion_flag      <= fus_en_q && !conc_c && sc_ok_s4;
			res_sd[0].span_deviation   <= '0;
			sat_sd[0] <= diff_x >= sat_lim;
			rem_sd[0] <= diff_x[SPREAD_W+DEV_FRAC-1:DEV_FRAC];
			num_sd[0] <= {diff_x[DEV_FRAC-1:0], {(DEV_W-DEV_FRAC){1'b0}}};
			quo_sd[0] <= '0;
		end
	end

	// stages 6..13: two quotient bits each
	for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
		logic [SPREAD_W:0] st_hi, st_lo;

		always_comb begin
			st_hi = div_step(rem_sd[d], num_sd[d][DEV_W-1], spread_q);
			st_lo = div_step(st_hi[SPREAD_W-1:0], num_sd[d][DEV_W-2], spread_q);
		end

		always_ff @(posedge clk) begin
			if (adv[6+d]) begin
				res_sd[d+1] <= res_sd[d];
				sat_sd[d+1] <= sat_sd[d];
				rem_sd[d+1] <= st_lo[SPREAD_W-1:0];
				num_sd[d+1] <= {num_sd[d][DEV_W-3:0], 2'b00};
				quo_sd[d+1] <= {quo_sd[d][DEV_W-3:0], st_hi[SPREAD_W], st_lo[SPREAD_W]};
			end
		end
	end

	always_comb begin
		result                = res_sd[DIV_STAGES];
		result.span_deviation = sat_sd[DIV_STAGES] ? {DEV_W{1'b1}} : quo_sd[DIV_STAGES];
	end

	a_fusion_discordant: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.fusion_flag && result.concordant))
		else $error("fusion flagged on a concordant pair");

	a_conc_orient: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.concordant |->
			(result.pair_orientation == ORIENT_FR) || (result.pair_orientation == ORIENT_RF))
		else $error("concordant pair with same-strand orientation");

	a_zero_spread_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (spread_q == '0) |-> result.span_deviation == {DEV_W{1'b1}})
		else $error("deviation not saturated with zero spread");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NS] |-> pair_ready)
		else $error("input stalled while output stage is empty");

endmodule

`default_nettype wire
